[sv/ipv6hp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IPv6 header parser package
// Shared types, constants and the next-header classifier for the parser.
// ----------------------------------------------------------------------------
package ipv6hp_pkg;

  // Fixed header geometry.
  localparam int HEADER_BYTES  = 40;
  localparam int ADDRESS_BYTES = 16;
  localparam int FIXED_BYTES   = HEADER_BYTES - 2 * ADDRESS_BYTES;
  localparam int WORD_BYTES    = ADDRESS_BYTES / 2;
  localparam int IDX_W         = 6;

  typedef logic [IDX_W-1:0] idx_t;

  // Byte positions where each header word ends.
  localparam idx_t IDX_FIXED_END  = idx_t'(FIXED_BYTES);
  localparam idx_t IDX_SRC_HI_END = idx_t'(FIXED_BYTES + WORD_BYTES);
  localparam idx_t IDX_SRC_LO_END = idx_t'(FIXED_BYTES + ADDRESS_BYTES);
  localparam idx_t IDX_DST_HI_END = idx_t'(FIXED_BYTES + ADDRESS_BYTES + WORD_BYTES);
  localparam idx_t IDX_HDR_END    = idx_t'(HEADER_BYTES);
  localparam idx_t IDX_HDR_LAST   = idx_t'(HEADER_BYTES - 1);

  localparam logic [3:0] IP_VERSION_6 = 4'd6;

  // Next header protocol numbers.
  localparam logic [7:0] NH_HOPOPT    = 8'd0;
  localparam logic [7:0] NH_ICMP      = 8'd1;
  localparam logic [7:0] NH_IPIP      = 8'd4;
  localparam logic [7:0] NH_TCP       = 8'd6;
  localparam logic [7:0] NH_UDP       = 8'd17;
  localparam logic [7:0] NH_ROUTING   = 8'd43;
  localparam logic [7:0] NH_FRAGMENT  = 8'd44;
  localparam logic [7:0] NH_ESP       = 8'd50;
  localparam logic [7:0] NH_AH        = 8'd51;
  localparam logic [7:0] NH_ICMPV6    = 8'd58;
  localparam logic [7:0] NH_DSTOPTS   = 8'd60;

  typedef enum logic [1:0] {
    CLASS_UPPER = 2'd0,
    CLASS_EXT   = 2'd1,
    CLASS_OTHER = 2'd2
  } hdr_class_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [5:0]  dscp;
    logic [1:0]  ecn;
    logic [19:0] flow_label;
    logic [15:0] payload_length;
    logic [7:0]  next_header;
    logic [7:0]  hops_left;
    logic [63:0] source_high;
    logic [63:0] source_low;
    logic [63:0] destination_high;
    logic [63:0] destination_low;
    logic [1:0]  header_class;
  } out_item_t;

  // Header words as they stand after the current byte.
  typedef struct packed {
    logic [63:0] fixed;
    logic [63:0] src_hi;
    logic [63:0] src_lo;
    logic [63:0] dst_hi;
    logic [63:0] dst_lo;
  } hdr_words_t;

  // Control and status from the byte collector.
  typedef struct packed {
    logic emit_full;
    logic emit_short;
    logic reported;
    idx_t byte_idx;
  } coll_flags_t;

  function automatic hdr_class_e classify(input logic [7:0] nh);
    hdr_class_e c;
    case (nh)
      NH_ICMP, NH_TCP, NH_UDP, NH_ICMPV6: c = CLASS_UPPER;
      NH_HOPOPT, NH_IPIP, NH_ROUTING, NH_FRAGMENT,
      NH_ESP, NH_AH, NH_DSTOPTS:          c = CLASS_EXT;
      default:                            c = CLASS_OTHER;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

[sv/ipv6hp_stream_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IPv6 header parser stream interface
// Valid/ready channel that carries one item of the given payload type.
// ----------------------------------------------------------------------------
interface ipv6hp_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

[sv/ipv6hp_collector.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IPv6 header byte collector
// Counts packet bytes and shifts the 40 header bytes into five 64-bit words.
// ----------------------------------------------------------------------------
module ipv6hp_collector import ipv6hp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        take_i,
  input  logic [7:0]  data_i,
  input  logic        last_i,
  output hdr_words_t  words_o,
  output coll_flags_t flags_o
);

  idx_t       idx_q, idx_d;
  logic       rep_q, rep_d;
  hdr_words_t words_q, words_d;

  // Next words with the current byte shifted into the word it belongs to.
  always_comb begin
    words_d = words_q;
    if (!rep_q) begin
      if (idx_q < IDX_FIXED_END) begin
        words_d.fixed = {words_q.fixed[55:0], data_i};
      end else if (idx_q < IDX_SRC_HI_END) begin
        words_d.src_hi = {words_q.src_hi[55:0], data_i};
      end else if (idx_q < IDX_SRC_LO_END) begin
        words_d.src_lo = {words_q.src_lo[55:0], data_i};
      end else if (idx_q < IDX_DST_HI_END) begin
        words_d.dst_hi = {words_q.dst_hi[55:0], data_i};
      end else if (idx_q < IDX_HDR_END) begin
        words_d.dst_lo = {words_q.dst_lo[55:0], data_i};
      end
    end
  end

  always_comb begin
    idx_d = idx_q;
    rep_d = rep_q;
    if (!rep_q) begin
      if (idx_q < IDX_HDR_END) begin
        idx_d = idx_q + idx_t'(1);
      end
      if (idx_q == IDX_HDR_LAST) begin
        rep_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      rep_q   <= 1'b0;
      words_q <= '0;
    end else if (take_i) begin
      if (last_i) begin
        idx_q   <= '0;
        rep_q   <= 1'b0;
        words_q <= '0;
      end else begin
        idx_q   <= idx_d;
        rep_q   <= rep_d;
        words_q <= words_d;
      end
    end
  end

  assign words_o            = words_d;
  assign flags_o.emit_full  = !rep_q && (idx_q == IDX_HDR_LAST);
  assign flags_o.emit_short = !rep_q && last_i && (idx_q != IDX_HDR_LAST);
  assign flags_o.reported   = rep_q;
  assign flags_o.byte_idx   = idx_q;

endmodule
`default_nettype wire

[sv/ipv6hp_decode.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IPv6 header field decoder
// Splits the gathered header into result fields and checks its validity.
// ----------------------------------------------------------------------------
module ipv6hp_decode import ipv6hp_pkg::*; (
  input  hdr_words_t words_i,
  input  logic       short_i,
  output out_item_t  item_o
);

  logic [7:0]  b0;
  logic [7:0]  b1;
  logic [15:0] plen;
  logic [7:0]  nh;
  logic [7:0]  hop;
  logic        bad;

  assign b0   = words_i.fixed[63:56];
  assign b1   = words_i.fixed[55:48];
  assign plen = words_i.fixed[31:16];
  assign nh   = words_i.fixed[15:8];
  assign hop  = words_i.fixed[7:0];
  assign bad  = (b0[7:4] != IP_VERSION_6) || (plen == 16'd0) || (hop == 8'd0);

  // A packet that ends before the header is complete reports only the error.
  always_comb begin
    if (short_i) begin
      item_o        = '0;
      item_o.status = 1'b1;
    end else begin
      item_o.status           = bad;
      item_o.dscp             = {b0[3:0], b1[7:6]};
      item_o.ecn              = b1[5:4];
      item_o.flow_label       = {b1[3:0], words_i.fixed[47:32]};
      item_o.payload_length   = plen;
      item_o.next_header      = nh;
      item_o.hops_left        = hop;
      item_o.source_high      = words_i.src_hi;
      item_o.source_low       = words_i.src_lo;
      item_o.destination_high = words_i.dst_hi;
      item_o.destination_low  = words_i.dst_lo;
      item_o.header_class     = classify(nh);
    end
  end

endmodule
`default_nettype wire

[sv/ipv6_header_parser_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IPv6 fixed header parser
// Gathers the 40-byte IPv6 fixed header from a byte stream and reports it.
// ----------------------------------------------------------------------------
// The input channel in_i carries one packet byte per item together with a
// mark on the final byte of the packet. The output channel out_o carries one
// decoded header per packet: on the fortieth byte the full header is given,
// with status set when the version, payload length or hop limit is wrong. A
// packet that ends earlier gives one item with only the status bit set.
// Bytes after the header are dropped until the final byte arrives.
// Each byte passes an input register and then the collector; a result is
// written into the output register when its byte leaves the input register,
// and out_o offers it from that register. One byte is taken in every cycle
// while no result is stalled as told below; the rate is set by the
// single-byte datapath of the collector.
// Reset clears the collector, its header words and the valid flags of both channel registers.
// When the receiver stalls, bytes that cause no result keep flowing; only a
// byte that would produce a new result waits in the input register while
// the output register still holds an untaken item.
// ----------------------------------------------------------------------------
module ipv6_header_parser_top import ipv6hp_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  ipv6hp_stream_if.sink   in_i,
  ipv6hp_stream_if.source out_o
);

  // Input register.
  logic     in_vld_q;
  in_item_t in_q;

  // Output register.
  logic      out_vld_q, out_vld_d;
  out_item_t out_q;

  hdr_words_t  words;
  coll_flags_t flags;
  out_item_t   item;
  logic        emit;
  logic        take;

  // The byte in the input register moves on unless it would produce a
  // result that the full output register cannot take.
  assign emit      = flags.emit_full || flags.emit_short;
  assign take      = in_vld_q && (!emit || !out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= in_i.payload;
    end
  end

  ipv6hp_collector u_collector (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (take),
    .data_i  (in_q.data_byte),
    .last_i  (in_q.last_byte),
    .words_o (words),
    .flags_o (flags)
  );

  ipv6hp_decode u_decode (
    .words_i (words),
    .short_i (flags.emit_short),
    .item_o  (item)
  );

  always_comb begin
    if (take && emit) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && emit) begin
      out_q <= item;
    end
  end

  assign out_o.valid   = out_vld_q;
  assign out_o.payload = out_q;

  // A new result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_o.ready) |-> !(take && emit))
    else $error("result register overwritten while stalled");

  // Once the header has been reported the index rests at the header length.
  a_reported_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags.reported |-> (flags.byte_idx == IDX_HDR_END))
    else $error("header reported with wrong byte index");

  // The final byte of a packet returns the collector to its start.
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && in_q.last_byte) |=> (flags.byte_idx == '0 && !flags.reported))
    else $error("collector not cleared after final byte");

  // Full and short results are mutually exclusive.
  a_emit_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(flags.emit_full && flags.emit_short))
    else $error("full and short result at once");

endmodule
`default_nettype wire
